[src/chca_pkg.sv]
// Shared types, constants and the arctangent table of the compass heading unit.
package chca_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int CORDIC_STEPS_DEF    = 16;

    localparam int INNER_FRAC  = 20;
    localparam int TRIG_FRAC   = 30;
    localparam int TABLE_LEN   = 24;
    localparam int TAB_W       = 27;
    localparam int MAG_W       = 16;
    localparam int MAG_SHIFT   = 16;
    localparam int VEC_W       = 35;
    localparam int ROT_W       = 33;
    localparam int Z_W         = 31;
    localparam int PROD_W      = 40;
    localparam int OFS_W       = 8;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int GAIN_Q30    = 652032875;

    localparam logic [6:0] RESET_CENTER_X     = 7'd96;
    localparam logic [5:0] RESET_CENTER_Y     = 6'd32;
    localparam logic [5:0] RESET_ARROW_LENGTH = 6'd25;

    typedef enum logic [1:0] {
        REG_CENTER_X     = 2'b00,
        REG_CENTER_Y     = 2'b01,
        REG_ARROW_LENGTH = 2'b10
    } reg_idx_t;

    typedef struct packed {
        logic [6:0] center_x;
        logic [5:0] center_y;
        logic [5:0] arrow_length;
    } cfg_t;

    typedef struct packed {
        logic ok;
        logic zero_h;
    } vec_side_t;

    typedef struct packed {
        logic [8:0]  heading_number;
        logic [15:0] arrow_angle;
        logic        ok;
    } rot_side_t;

    typedef struct packed {
        rot_side_t base;
        logic      neg;
    } trig_side_t;

    function automatic logic [TAB_W-1:0] atan_entry(input int idx);
        logic [TAB_W-1:0] v;
        case (idx)
            0:       v = 27'd47185920;
            1:       v = 27'd27855475;
            2:       v = 27'd14718068;
            3:       v = 27'd7471121;
            4:       v = 27'd3750058;
            5:       v = 27'd1876857;
            6:       v = 27'd938658;
            7:       v = 27'd469357;
            8:       v = 27'd234682;
            9:       v = 27'd117342;
            10:      v = 27'd58671;
            11:      v = 27'd29335;
            12:      v = 27'd14668;
            13:      v = 27'd7334;
            14:      v = 27'd3667;
            15:      v = 27'd1833;
            16:      v = 27'd917;
            17:      v = 27'd458;
            18:      v = 27'd229;
            19:      v = 27'd115;
            20:      v = 27'd57;
            21:      v = 27'd29;
            22:      v = 27'd14;
            23:      v = 27'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/compass_heading_arrow_unit.sv]
// Top level of the compass heading and arrow unit.
//
//   channel   direction  handshake            payload
//   input     in         in_valid/in_ready    mag_x, mag_y, sample_ok
//   output    out        out_valid/out_ready  heading_number, arrow_angle, tip/tail x/y, data_ok
//   config    in         APB psel/penable     paddr, pwdata, prdata
//
// One transaction per cycle while out_ready is high; the two unrolled CORDIC pipelines
// have one stage per micro-rotation.
// Every stage holds its own valid bit; a stage advances when empty or when the
// stage after it advances, so bubbles close up under an output stall.
// Reset clears the valid bits and loads the register defaults.
module compass_heading_arrow_unit #(
    parameter int ANGLE_FRAC_BITS = chca_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = chca_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [chca_pkg::MAG_W-1:0] mag_x,
    input  logic signed [chca_pkg::MAG_W-1:0] mag_y,
    input  logic                              sample_ok,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [8:0]                        heading_number,
    output logic [15:0]                       arrow_angle,
    output logic signed [8:0]                 tip_x,
    output logic signed [7:0]                 tip_y,
    output logic signed [8:0]                 tail_x,
    output logic signed [7:0]                 tail_y,
    output logic                              data_ok,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chca_pkg::ADDR_W-1:0]       paddr,
    input  logic [chca_pkg::DATA_W-1:0]       pwdata,
    output logic [chca_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import chca_pkg::*;

    localparam int HeadW = $clog2(360 << ANGLE_FRAC_BITS);
    localparam int AW    = (HeadW > 16) ? HeadW : 16;
    localparam logic [AW-1:0] ArrowIdle = AW'(180 << ANGLE_FRAC_BITS);

    cfg_t cfg;

    logic                  vec_valid;
    logic                  vec_ready;
    logic signed [Z_W-1:0] vec_z;
    vec_side_t             vec_side;

    logic                  ang_valid;
    logic                  ang_ready;
    logic [HeadW-1:0]      ang_arrow;
    rot_side_t             ang_side;

    logic                    rot_valid;
    logic                    rot_ready;
    logic signed [ROT_W-1:0] rot_cos;
    logic signed [ROT_W-1:0] rot_sin;
    trig_side_t              rot_side;

    chca_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    chca_vector #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .sample_ok (sample_ok),
        .out_valid (vec_valid),
        .out_ready (vec_ready),
        .z_out     (vec_z),
        .side_out  (vec_side)
    );

    chca_angle #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_valid),
        .in_ready  (vec_ready),
        .z_in      (vec_z),
        .side_in   (vec_side),
        .out_valid (ang_valid),
        .out_ready (ang_ready),
        .arrow     (ang_arrow),
        .side_out  (ang_side)
    );

    chca_rotate #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ang_valid),
        .in_ready  (ang_ready),
        .arrow     (ang_arrow),
        .side_in   (ang_side),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .cos_q     (rot_cos),
        .sin_q     (rot_sin),
        .side_out  (rot_side)
    );

    chca_place u_place (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (rot_valid),
        .in_ready       (rot_ready),
        .cos_q          (rot_cos),
        .sin_q          (rot_sin),
        .side_in        (rot_side),
        .cfg            (cfg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .heading_number (heading_number),
        .arrow_angle    (arrow_angle),
        .tip_x          (tip_x),
        .tip_y          (tip_y),
        .tail_x         (tail_x),
        .tail_y         (tail_y),
        .data_ok        (data_ok)
    );

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading_number < 9'd360)
        else $error("heading_number out of range");

    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_ok |-> heading_number == 9'd180 && arrow_angle == ArrowIdle[15:0])
        else $error("invalid sample must give a zero heading");

    a_symmetric_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 9'(tip_x + tail_x) == {1'b0, cfg.center_x, 1'b0})
        else $error("tip and tail x not symmetric about the centre");

    a_symmetric_y: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 8'(tip_y + tail_y) == {1'b0, cfg.center_y, 1'b0})
        else $error("tip and tail y not symmetric about the centre");

endmodule

[src/chca_regs.sv]
// APB register file holding dial centre and arrow length.
module chca_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [chca_pkg::ADDR_W-1:0] paddr,
    input  logic [chca_pkg::DATA_W-1:0] pwdata,
    output logic [chca_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output chca_pkg::cfg_t              cfg
);
    import chca_pkg::*;

    logic [6:0] center_x_reg;
    logic [5:0] center_y_reg;
    logic [5:0] arrow_length_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= RESET_CENTER_X;
            center_y_reg     <= RESET_CENTER_Y;
            arrow_length_reg <= RESET_ARROW_LENGTH;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CENTER_X:     center_x_reg     <= pwdata[6:0];
                REG_CENTER_Y:     center_y_reg     <= pwdata[5:0];
                REG_ARROW_LENGTH: arrow_length_reg <= pwdata[5:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CENTER_X:     prdata = DATA_W'(center_x_reg);
            REG_CENTER_Y:     prdata = DATA_W'(center_y_reg);
            REG_ARROW_LENGTH: prdata = DATA_W'(arrow_length_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.center_x     = center_x_reg;
    assign cfg.center_y     = center_y_reg;
    assign cfg.arrow_length = arrow_length_reg;

endmodule

[src/chca_vector.sv]
// Pipelined vectoring CORDIC: angle of the magnetometer vector in inner degrees.
module chca_vector #(
    parameter int CORDIC_STEPS = chca_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [chca_pkg::MAG_W-1:0] mag_x,
    input  logic signed [chca_pkg::MAG_W-1:0] mag_y,
    input  logic                              sample_ok,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [chca_pkg::Z_W-1:0]   z_out,
    output chca_pkg::vec_side_t               side_out
);
    import chca_pkg::*;

    localparam int Steps = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam logic signed [Z_W-1:0] Z180 = Z_W'(180 << INNER_FRAC);

    logic [Steps:0]   v_reg;
    logic [Steps+1:0] rdy;

    logic signed [VEC_W-1:0] x_w [Steps];
    logic signed [VEC_W-1:0] y_w [Steps];
    logic signed [Z_W-1:0]   z_w [Steps+1];
    vec_side_t               s_w [Steps+1];

    logic signed [VEC_W-1:0] sx;
    logic signed [VEC_W-1:0] sy;
    logic signed [VEC_W-1:0] x0_reg;
    logic signed [VEC_W-1:0] y0_reg;
    logic signed [Z_W-1:0]   z0_reg;
    vec_side_t               s0_reg;

    assign sx = VEC_W'(mag_x) <<< MAG_SHIFT;
    assign sy = VEC_W'(mag_y) <<< MAG_SHIFT;

    // turn left half-plane vectors by 180 degrees
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x0_reg        <= mag_x[MAG_W-1] ? -sx : sx;
            y0_reg        <= mag_x[MAG_W-1] ? -sy : sy;
            z0_reg        <= mag_x[MAG_W-1] ? Z180 : '0;
            s0_reg.ok     <= sample_ok;
            s0_reg.zero_h <= !sample_ok || (mag_x == '0 && mag_y == '0);
        end
    end

    assign x_w[0] = x0_reg;
    assign y_w[0] = y0_reg;
    assign z_w[0] = z0_reg;
    assign s_w[0] = s0_reg;

    for (genvar i = 0; i < Steps; i++)
    begin : g_iter
        localparam logic signed [Z_W-1:0] Tab = Z_W'(atan_entry(i));
        logic                  dir;
        logic signed [Z_W-1:0] z_reg;
        vec_side_t             side_reg;

        assign dir = !y_w[i][VEC_W-1];

        always_ff @(posedge clk)
        begin
            if (rdy[i+1])
            begin
                z_reg    <= dir ? z_w[i] + Tab : z_w[i] - Tab;
                side_reg <= s_w[i];
            end
        end

        assign z_w[i+1] = z_reg;
        assign s_w[i+1] = side_reg;

        if (i < Steps - 1)
        begin : g_xy
            logic signed [VEC_W-1:0] x_reg;
            logic signed [VEC_W-1:0] y_reg;

            always_ff @(posedge clk)
            begin
                if (rdy[i+1])
                begin
                    x_reg <= dir ? x_w[i] + (y_w[i] >>> i) : x_w[i] - (y_w[i] >>> i);
                    y_reg <= dir ? y_w[i] - (x_w[i] >>> i) : y_w[i] + (x_w[i] >>> i);
                end
            end

            assign x_w[i+1] = x_reg;
            assign y_w[i+1] = y_reg;
        end
    end

    assign rdy[Steps+1] = out_ready;
    for (genvar k = 0; k <= Steps; k++)
    begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k <= Steps; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[Steps];
    assign z_out     = z_w[Steps];
    assign side_out  = s_w[Steps];

endmodule

[src/chca_angle.sv]
// Heading rounding and wrap, displayed number and arrow angle, three stages.
module chca_angle #(
    parameter int ANGLE_FRAC_BITS = chca_pkg::ANGLE_FRAC_BITS_DEF,
    localparam int HeadW = $clog2(360 << ANGLE_FRAC_BITS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [chca_pkg::Z_W-1:0] z_in,
    input  chca_pkg::vec_side_t             side_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [HeadW-1:0]                arrow,
    output chca_pkg::rot_side_t             side_out
);
    import chca_pkg::*;

    localparam int Shift = INNER_FRAC - ANGLE_FRAC_BITS;
    localparam int AW    = (HeadW > 16) ? HeadW : 16;
    localparam logic signed [Z_W-1:0] Rnd    = Z_W'(1 << (Shift - 1));
    localparam logic signed [Z_W-1:0] RndWrp = Z_W'((360 << INNER_FRAC) + (1 << (Shift - 1)));
    localparam logic [HeadW:0] Full    = (HeadW+1)'(360 << ANGLE_FRAC_BITS);
    localparam logic [HeadW:0] Half    = (HeadW+1)'(180 << ANGLE_FRAC_BITS);
    localparam logic [HeadW:0] NumBase = (HeadW+1)'(540 << ANGLE_FRAC_BITS);

    logic [2:0] v_reg;
    logic [3:0] rdy;

    logic signed [Z_W-1:0] zr;
    logic [HeadW-1:0]      ha_reg;
    logic                  oka_reg;
    logic [HeadW-1:0]      hb_reg;
    logic                  okb_reg;
    logic [HeadW:0]        hb_ext;
    logic [HeadW:0]        num;
    logic [HeadW:0]        num_w;
    logic [HeadW:0]        arr;
    logic [HeadW:0]        arr_w;
    logic [AW-1:0]         arr_a;
    logic [HeadW-1:0]      arrow_reg;
    rot_side_t             side_reg;

    assign zr = z_in + (z_in[Z_W-1] ? RndWrp : Rnd);

    // round to the output grid
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ha_reg  <= side_in.zero_h ? '0 : HeadW'(zr >>> Shift);
            oka_reg <= side_in.ok;
        end
    end

    // wrap a full turn to zero
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            hb_reg  <= ({1'b0, ha_reg} >= Full) ? HeadW'({1'b0, ha_reg} - Full) : ha_reg;
            okb_reg <= oka_reg;
        end
    end

    assign hb_ext = {1'b0, hb_reg};
    assign num    = NumBase - hb_ext;
    assign num_w  = (num >= Full) ? num - Full : num;
    assign arr    = hb_ext + Half;
    assign arr_w  = (arr >= Full) ? arr - Full : arr;
    assign arr_a  = AW'(arr_w);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            arrow_reg               <= HeadW'(arr_w);
            side_reg.heading_number <= 9'(num_w >> ANGLE_FRAC_BITS);
            side_reg.arrow_angle    <= arr_a[15:0];
            side_reg.ok             <= okb_reg;
        end
    end

    assign rdy[3] = out_ready;
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (rdy[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[2];
    assign arrow     = arrow_reg;
    assign side_out  = side_reg;

endmodule

[src/chca_rotate.sv]
// Pipelined rotation CORDIC: cosine and sine of the arrow angle folded into the right half-plane, in Q30.
module chca_rotate #(
    parameter int ANGLE_FRAC_BITS = chca_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = chca_pkg::CORDIC_STEPS_DEF,
    localparam int HeadW = $clog2(360 << ANGLE_FRAC_BITS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [HeadW-1:0]                  arrow,
    input  chca_pkg::rot_side_t               side_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [chca_pkg::ROT_W-1:0] cos_q,
    output logic signed [chca_pkg::ROT_W-1:0] sin_q,
    output chca_pkg::trig_side_t              side_out
);
    import chca_pkg::*;

    localparam int Steps = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int Shift = INNER_FRAC - ANGLE_FRAC_BITS;
    localparam logic [HeadW-1:0] Q90  = HeadW'(90 << ANGLE_FRAC_BITS);
    localparam logic [HeadW-1:0] Q270 = HeadW'(270 << ANGLE_FRAC_BITS);
    localparam logic signed [HeadW:0] Q180 = (HeadW+1)'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [HeadW:0] Q360 = (HeadW+1)'(360 << ANGLE_FRAC_BITS);
    localparam logic signed [ROT_W-1:0] Gain = ROT_W'(GAIN_Q30);

    logic [Steps:0]   v_reg;
    logic [Steps+1:0] rdy;

    logic signed [ROT_W-1:0] x_w [Steps+1];
    logic signed [ROT_W-1:0] y_w [Steps+1];
    logic signed [Z_W-1:0]   z_w [Steps];
    trig_side_t              s_w [Steps+1];

    logic signed [HeadW:0]   af;
    logic signed [HeadW:0]   zf;
    logic                    fold;
    logic signed [ROT_W-1:0] x0_reg;
    logic signed [ROT_W-1:0] y0_reg;
    logic signed [Z_W-1:0]   z0_reg;
    trig_side_t              s0_reg;

    // fold into the right half-plane
    assign af   = $signed({1'b0, arrow});
    assign fold = (arrow > Q90) && (arrow < Q270);
    assign zf   = fold ? af - Q180 : ((arrow >= Q270) ? af - Q360 : af);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x0_reg      <= Gain;
            y0_reg      <= '0;
            z0_reg      <= Z_W'(zf) <<< Shift;
            s0_reg.base <= side_in;
            s0_reg.neg  <= fold;
        end
    end

    assign x_w[0] = x0_reg;
    assign y_w[0] = y0_reg;
    assign z_w[0] = z0_reg;
    assign s_w[0] = s0_reg;

    for (genvar i = 0; i < Steps; i++)
    begin : g_iter
        localparam logic signed [Z_W-1:0] Tab = Z_W'(atan_entry(i));
        logic                    dir;
        logic signed [ROT_W-1:0] x_reg;
        logic signed [ROT_W-1:0] y_reg;
        trig_side_t              side_reg;

        assign dir = !z_w[i][Z_W-1];

        always_ff @(posedge clk)
        begin
            if (rdy[i+1])
            begin
                x_reg    <= dir ? x_w[i] - (y_w[i] >>> i) : x_w[i] + (y_w[i] >>> i);
                y_reg    <= dir ? y_w[i] + (x_w[i] >>> i) : y_w[i] - (x_w[i] >>> i);
                side_reg <= s_w[i];
            end
        end

        assign x_w[i+1] = x_reg;
        assign y_w[i+1] = y_reg;
        assign s_w[i+1] = side_reg;

        if (i < Steps - 1)
        begin : g_z
            logic signed [Z_W-1:0] z_reg;

            always_ff @(posedge clk)
            begin
                if (rdy[i+1])
                begin
                    z_reg <= dir ? z_w[i] - Tab : z_w[i] + Tab;
                end
            end

            assign z_w[i+1] = z_reg;
        end
    end

    assign rdy[Steps+1] = out_ready;
    for (genvar k = 0; k <= Steps; k++)
    begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k <= Steps; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[Steps];
    assign cos_q     = x_w[Steps];
    assign sin_q     = y_w[Steps];
    assign side_out  = s_w[Steps];

endmodule

[src/chca_place.sv]
// Arrow length scaling and tip/tail placement with the output register.
module chca_place (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [chca_pkg::ROT_W-1:0] cos_q,
    input  logic signed [chca_pkg::ROT_W-1:0] sin_q,
    input  chca_pkg::trig_side_t              side_in,
    input  chca_pkg::cfg_t                    cfg,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [8:0]                        heading_number,
    output logic [15:0]                       arrow_angle,
    output logic signed [8:0]                 tip_x,
    output logic signed [7:0]                 tip_y,
    output logic signed [8:0]                 tail_x,
    output logic signed [7:0]                 tail_y,
    output logic                              data_ok
);
    import chca_pkg::*;

    localparam logic signed [PROD_W-1:0] Bias = PROD_W'((64'd1 << TRIG_FRAC) - 64'd1);

    logic [1:0] v_reg;
    logic [2:0] rdy;

    logic signed [PROD_W-1:0] len_s;
    logic signed [PROD_W-1:0] pc_reg;
    logic signed [PROD_W-1:0] ps_reg;
    trig_side_t               sm_reg;

    logic signed [PROD_W-1:0] qc;
    logic signed [PROD_W-1:0] qs;
    logic signed [OFS_W-1:0]  tc;
    logic signed [OFS_W-1:0]  ts;
    logic signed [OFS_W-1:0]  dx;
    logic signed [OFS_W-1:0]  dy;
    logic signed [8:0]        cx9;
    logic signed [7:0]        cy8;

    logic [8:0]        heading_number_reg;
    logic [15:0]       arrow_angle_reg;
    logic signed [8:0] tip_x_reg;
    logic signed [7:0] tip_y_reg;
    logic signed [8:0] tail_x_reg;
    logic signed [7:0] tail_y_reg;
    logic              data_ok_reg;

    assign len_s = PROD_W'($signed({1'b0, cfg.arrow_length}));

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pc_reg <= PROD_W'(cos_q) * len_s;
            ps_reg <= PROD_W'(sin_q) * len_s;
            sm_reg <= side_in;
        end
    end

    // truncate toward zero, then undo the fold
    assign qc  = (pc_reg + (pc_reg[PROD_W-1] ? Bias : '0)) >>> TRIG_FRAC;
    assign qs  = (ps_reg + (ps_reg[PROD_W-1] ? Bias : '0)) >>> TRIG_FRAC;
    assign tc  = qc[OFS_W-1:0];
    assign ts  = qs[OFS_W-1:0];
    assign dx  = sm_reg.neg ? -tc : tc;
    assign dy  = sm_reg.neg ? -ts : ts;
    assign cx9 = $signed({2'b00, cfg.center_x});
    assign cy8 = $signed({2'b00, cfg.center_y});

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            heading_number_reg <= sm_reg.base.heading_number;
            arrow_angle_reg    <= sm_reg.base.arrow_angle;
            data_ok_reg        <= sm_reg.base.ok;
            tip_x_reg          <= cx9 + 9'(dx);
            tail_x_reg         <= cx9 - 9'(dx);
            tip_y_reg          <= cy8 + dy;
            tail_y_reg         <= cy8 - dy;
        end
    end

    assign rdy[2] = out_ready;
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    assign in_ready       = rdy[0];
    assign out_valid      = v_reg[1];
    assign heading_number = heading_number_reg;
    assign arrow_angle    = arrow_angle_reg;
    assign tip_x          = tip_x_reg;
    assign tip_y          = tip_y_reg;
    assign tail_x         = tail_x_reg;
    assign tail_y         = tail_y_reg;
    assign data_ok        = data_ok_reg;

endmodule

[test/compass_heading_arrow_unit_tb.sv]
// Self-checking testbench for the compass heading and arrow unit: directed and random samples.
module compass_heading_arrow_unit_tb;
    import chca_pkg::*;

    localparam int FRAC_BITS    = ANGLE_FRAC_BITS_DEF;
    localparam int STEPS        = CORDIC_STEPS_DEF;
    localparam int USED_STEPS   = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
    localparam int PIPE_LATENCY = 2 * STEPS + 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int RANDOM_PHASES = 6;
    localparam int REG_UNUSED   = 3;

    typedef struct packed {
        logic [8:0]  heading_number;
        logic [15:0] arrow_angle;
        logic [8:0]  tip_x;
        logic [7:0]  tip_y;
        logic [8:0]  tail_x;
        logic [7:0]  tail_y;
        logic        data_ok;
    } heading_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [MAG_W-1:0]  mag_x = '0;
    logic signed [MAG_W-1:0]  mag_y = '0;
    logic                     sample_ok = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [8:0]               heading_number;
    logic [15:0]              arrow_angle;
    logic signed [8:0]        tip_x;
    logic signed [7:0]        tip_y;
    logic signed [8:0]        tail_x;
    logic signed [7:0]        tail_y;
    logic                     data_ok;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    heading_result_t pending_headings[$];
    int              error_count = 0;
    int              cycle_count = 0;
    int              stall_left = 0;
    bit              idle_enabled = 1'b0;
    logic [6:0]      center_x_now = RESET_CENTER_X;
    logic [5:0]      center_y_now = RESET_CENTER_Y;
    logic [5:0]      arrow_length_now = RESET_ARROW_LENGTH;

    longint atan_deg_q20 [0:TABLE_LEN-1] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    compass_heading_arrow_unit #(
        .ANGLE_FRAC_BITS (FRAC_BITS),
        .CORDIC_STEPS    (STEPS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mag_x          (mag_x),
        .mag_y          (mag_y),
        .sample_ok      (sample_ok),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .heading_number (heading_number),
        .arrow_angle    (arrow_angle),
        .tip_x          (tip_x),
        .tip_y          (tip_y),
        .tail_x         (tail_x),
        .tail_y         (tail_y),
        .data_ok        (data_ok),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 clk = ~clk;

    function automatic longint heading_fixed(input longint mx, input longint my);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint h;
        longint full;
        int     i;
        full = longint'(360) << FRAC_BITS;
        if (mx == 0 && my == 0)
            return 0;
        x = mx * 65536;
        y = my * 65536;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = longint'(180) << INNER_FRAC;
        end
        for (i = 0; i < USED_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_deg_q20[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_deg_q20[i];
            end
        end
        if (z < 0)
            z = z + (longint'(360) << INNER_FRAC);
        h = (z + (longint'(1) << (INNER_FRAC - FRAC_BITS - 1))) >>> (INNER_FRAC - FRAC_BITS);
        if (h >= full)
            h = h - full;
        return h;
    endfunction

    function automatic void arrow_cos_sin(input longint a, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        longint d90;
        longint d180;
        bit     neg;
        int     i;
        z = a << (INNER_FRAC - FRAC_BITS);
        d90 = longint'(90) << INNER_FRAC;
        d180 = longint'(180) << INNER_FRAC;
        x = GAIN_Q30;
        y = 0;
        neg = 1'b0;
        if (z > d180)
            z = z - 2 * d180;
        if (z > d90)
        begin
            z = z - d180;
            neg = 1'b1;
        end
        else if (z < -d90)
        begin
            z = z + d180;
            neg = 1'b1;
        end
        for (i = 0; i < USED_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_deg_q20[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_deg_q20[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint trunc_q30(input longint v);
        if (v >= 0)
            return v >>> TRIG_FRAC;
        return -((-v) >>> TRIG_FRAC);
    endfunction

    function automatic heading_result_t predict_heading(input logic signed [MAG_W-1:0] mx,
                                                       input logic signed [MAG_W-1:0] my,
                                                       input logic ok);
        heading_result_t r;
        longint          full;
        longint          h;
        longint          num;
        longint          arrow;
        longint          c;
        longint          s;
        longint          tx;
        longint          ty;
        longint          cx;
        longint          cy;
        full = longint'(360) << FRAC_BITS;
        h = ok ? heading_fixed(longint'(mx), longint'(my)) : 0;
        num = (longint'(540) << FRAC_BITS) - h;
        if (num >= full)
            num = num - full;
        num = num >>> FRAC_BITS;
        arrow = h + (longint'(180) << FRAC_BITS);
        if (arrow >= full)
            arrow = arrow - full;
        arrow_cos_sin(arrow, c, s);
        tx = trunc_q30(longint'(arrow_length_now) * c);
        ty = trunc_q30(longint'(arrow_length_now) * s);
        cx = longint'(center_x_now);
        cy = longint'(center_y_now);
        r.heading_number = 9'(num);
        r.arrow_angle = 16'(arrow);
        r.tip_x = 9'(cx + tx);
        r.tip_y = 8'(cy + ty);
        r.tail_x = 9'(cx - tx);
        r.tail_y = 8'(cy - ty);
        r.data_ok = ok;
        return r;
    endfunction

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        heading_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_headings.size() == 0)
            begin
                error_count++;
                $display("%0t: output transaction with nothing pending, expected none, actual %0d",
                         $time, heading_number);
            end
            else
            begin
                want = pending_headings.pop_front();
                check_field("heading_number", int'(want.heading_number), int'(heading_number));
                check_field("arrow_angle", int'(want.arrow_angle), int'(arrow_angle));
                check_field("tip_x", int'($signed(want.tip_x)), int'(tip_x));
                check_field("tip_y", int'($signed(want.tip_y)), int'(tip_y));
                check_field("tail_x", int'($signed(want.tail_x)), int'(tail_x));
                check_field("tail_y", int'($signed(want.tail_y)), int'(tail_y));
                check_field("data_ok", int'(want.data_ok), int'(data_ok));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || !idle_enabled)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                stall_left <= $urandom_range(1, 17);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("compass_heading_arrow_unit verification failed");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [MAG_W-1:0] x, input logic signed [MAG_W-1:0] y,
                               input logic ok);
        if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mag_x <= x;
        mag_y <= y;
        sample_ok <= ok;
        do
            @(posedge clk);
        while (!in_ready);
        pending_headings.push_back(predict_heading(x, y, ok));
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_headings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input int idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] word;
        case (idx)
            REG_CENTER_X:     mask = 32'h7F;
            REG_CENTER_Y:     mask = 32'h3F;
            REG_ARROW_LENGTH: mask = 32'h3F;
            default:          mask = 32'h0;
        endcase
        word = ($urandom() & ~mask) | (value & mask);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_CENTER_X:     center_x_now = word[6:0];
            REG_CENTER_Y:     center_y_now = word[5:0];
            REG_ARROW_LENGTH: arrow_length_now = word[5:0];
            default:          ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_config(input logic [6:0] cx, input logic [5:0] cy,
                                    input logic [5:0] len);
        write_config(REG_CENTER_X, DATA_W'(cx));
        write_config(REG_CENTER_Y, DATA_W'(cy));
        write_config(REG_ARROW_LENGTH, DATA_W'(len));
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    task automatic send_random_sample();
        int x;
        int y;
        int d;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                x = $urandom();
                y = $urandom();
            end
            5, 6:
            begin
                x = $urandom_range(0, 8) - 4;
                y = $urandom_range(0, 8) - 4;
            end
            7:
            begin
                if ($urandom_range(0, 1))
                begin
                    x = $urandom();
                    y = 0;
                end
                else
                begin
                    x = 0;
                    y = $urandom();
                end
            end
            8:
            begin
                x = $urandom_range(0, 65535) - 32768;
                d = $urandom_range(0, 6) - 3;
                y = $urandom_range(0, 1) ? x + d : -x + d;
            end
            default:
            begin
                x = pick_extreme();
                y = pick_extreme();
            end
        endcase
        send_sample(MAG_W'(x), MAG_W'(y), $urandom_range(0, 7) != 0);
    endtask

    task automatic test_reset_values();
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 16'sh8000, 1'b1);
        send_sample(16'sh8000, 16'sh7FFF, 1'b1);
        send_sample(16'sh0000, 16'sh0000, 1'b1);
        send_sample(16'sh8000, 16'sh0000, 1'b1);
        send_sample(16'shFFFF, 16'sh0000, 1'b1);
        send_sample(16'sh7FFF, 16'sh0000, 1'b1);
        send_sample(16'sh0001, 16'sh0000, 1'b1);
        send_sample(16'sh0000, 16'sh7FFF, 1'b1);
        send_sample(16'sh0000, 16'sh8000, 1'b1);
        send_sample(16'sh0000, 16'sh0001, 1'b1);
        send_sample(16'sh0000, 16'shFFFF, 1'b1);
        send_sample(16'shFFFF, 16'shFFFF, 1'b1);
        send_sample(16'sh0001, 16'shFFFF, 1'b1);
        send_sample(16'sh1234, 16'shA5C3, 1'b0);
        send_sample(16'sh0000, 16'sh0000, 1'b0);
    endtask

    task automatic test_register_extremes();
        drain_pipeline();
        write_all_config(7'd0, 6'd0, 6'd0);
        send_sample(16'sh8000, 16'sh0000, 1'b1);
        send_sample(16'sh0000, 16'sh7FFF, 1'b1);
        send_sample(16'sh5A5A, 16'sh0F0F, 1'b0);
        drain_pipeline();
        write_all_config(7'd127, 6'd63, 6'd63);
        send_sample(16'sh7FFF, 16'sh0000, 1'b1);
        send_sample(16'sh0000, 16'sh8000, 1'b1);
        send_sample(16'sh8000, 16'sh0001, 1'b1);
        drain_pipeline();
        write_all_config(7'd0, 6'd63, 6'd63);
        write_config(REG_UNUSED, 32'h0);
        send_sample(16'sh7FFF, 16'sh0000, 1'b1);
        send_sample(16'sh0000, 16'sh0000, 1'b0);
    endtask

    task automatic test_random_samples();
        int phase;
        int n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_pipeline();
            if (phase == 1)
                write_all_config(7'd127, 6'd0, 6'd63);
            else
                write_all_config(7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                                 6'($urandom_range(0, 63)));
            idle_enabled <= (phase != 2) && (phase < RANDOM_PHASES - 2);
            for (n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
                send_random_sample();
        end
    endtask

    initial
    begin : main_sequence
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_enabled <= 1'b1;
        test_reset_values();
        test_register_extremes();
        test_random_samples();
        drain_pipeline();
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (error_count == 0)
            $display("compass_heading_arrow_unit verification clean");
        else
            $display("compass_heading_arrow_unit verification failed");
        $finish;
    end

endmodule
